>>> hdl/roiwm_pkg.sv
package roiwm_pkg;

  localparam logic [1:0] MODE_VOL_CONC  = 2'd0;
  localparam logic [1:0] MODE_VOL_COUNT = 2'd1;
  localparam logic [1:0] MODE_MEM_CONC  = 2'd2;
  localparam logic [1:0] MODE_MEM_COUNT = 2'd3;

  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_NUM_REGIONS = 2'd1;
  localparam logic [1:0] REG_MAP_ENABLE = 2'd2;

  localparam logic [9:0]  MOLECULES_PER_MOLE = 10'd602;
  localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] measure;
    logic [5:0]  roi_index;
    logic        included;
    logic        last_element;
  } request_t;

  typedef struct packed {
    logic [3:0]  column;
    logic [63:0] total_molecules;
    logic [63:0] average;
    logic        divide_by_zero;
    logic        index_error;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [63:0] moles;
    logic [63:0] molecules;
    logic [63:0] measure;
  } bin_t;

  // Adds two sums and clamps at all ones on overflow.
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? SAT64 : s[63:0];
  endfunction

endpackage

>>> hdl/roi_weighted_total_and_mean.sv
// Per element, the states run S_MUL then S_ACC in the membrane modes, S_MUL, S_SCALE, S_ACC
// in volume concentration mode, and S_MUL, S_REM, S_SCALE, S_ACC in volume particle count mode,
// where the conversion to moles takes two reciprocal multiplications and a remainder step.
// On the last element, each column passes through F_READ and F_CALC, and through the radix-2
// divider (F_DIV) when the column's measure is nonzero; results cannot be stalled.
// Synchronous reset clears configuration, the grand total and the region valid bits.
module roi_weighted_total_and_mean #(
  parameter int MAX_REGIONS = 15
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  roiwm_pkg::request_t request,
  output logic                busy,
  output logic                result_valid,
  output roiwm_pkg::result_t  result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  // Address width of the region memory; one region still needs one bit.
  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  // The divider works on an 80-bit dividend: a 64-bit sum shifted by 16.
  localparam int DIV_STEPS = 80;
  localparam int CW = $clog2(DIV_STEPS);
  // Reciprocals of 602, rounded up, exact for 32-bit and 26-bit dividends.
  localparam logic [32:0] RECIP_HI = 33'(((64'd1 << 42) + 64'd601) / 64'd602);
  localparam logic [26:0] RECIP_LO = 27'(((64'd1 << 36) + 64'd601) / 64'd602);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SCALE, S_REM, S_ACC, F_READ, F_CALC, F_DIV
  } state_t;

  state_t state;

  // Configuration registers. The write channel never stalls.
  logic [1:0] mode;
  logic [3:0] num_regions;
  logic       region_map_enabled;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= roiwm_pkg::MODE_VOL_CONC;
      num_regions <= '0;
      region_map_enabled <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        roiwm_pkg::REG_MODE:        mode <= cfg_data[1:0];
        roiwm_pkg::REG_NUM_REGIONS: num_regions <= cfg_data[3:0];
        roiwm_pkg::REG_MAP_ENABLE:  region_map_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective region count, clamped to the memory depth.
  logic [5:0] nreg;
  assign nreg = ({2'b00, num_regions} < 6'(MAX_REGIONS)) ? {2'b00, num_regions}
                                                         : 6'(MAX_REGIONS);

  // Region bins live in a single-port style memory: one read or one write per cycle.
  // Every access is sequenced by the state machine, so a write and a read of the same
  // entry never overlap and no forwarding path is needed. The grand total (column 0)
  // is kept in registers since every included element touches it.
  roiwm_pkg::bin_t mem [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] valid;
  roiwm_pkg::bin_t rd_data;
  logic            rd_valid;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  roiwm_pkg::bin_t wr_data;
  logic            clear_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Entries not written since the last flush read as zero.
  always_ff @(posedge clk) begin
    if (rst || clear_valid) begin
      valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // Latched request and per-element working registers.
  roiwm_pkg::request_t req_r;
  logic [1:0]  elem_mode;
  logic        region_hit;
  logic [AW-1:0] region_addr;
  logic [63:0] moles_r;
  logic [63:0] mols_r;
  logic        bad_label_seen;
  roiwm_pkg::bin_t total;
  // Upper quotient and remainder of the value divided by 602.
  logic [22:0] quo_hi;
  logic [9:0]  rem_lo;

  // Column counter for the flush, and the snapshot taken at the last element.
  logic [6:0]  col;
  logic [6:0]  ncols;
  logic        dz;

  // Restoring divider for the column averages: one quotient bit per cycle.
  logic [79:0] div_quo;
  logic [64:0] div_rem;
  logic [63:0] div_den;
  logic [CW-1:0] div_cnt;
  logic [64:0] div_shift;
  logic [64:0] div_diff;
  logic        div_ge;
  logic [79:0] div_quo_next;
  logic [64:0] div_rem_next;

  always_comb begin
    div_shift = {div_rem[63:0], div_quo[79]};
    div_diff  = div_shift - {1'b0, div_den};
    div_ge    = div_shift >= {1'b0, div_den};
    div_rem_next = div_ge ? div_diff : div_shift;
    div_quo_next = {div_quo[78:0], div_ge};
  end

  // Element-side arithmetic.
  logic [63:0] prod_vm;
  logic [73:0] prod_602;
  logic [63:0] mols_scaled;
  logic [63:0] value_sh;
  logic        accept;
  logic [5:0]  req_idx;
  logic        vol_now;
  logic        hit_now;
  logic [64:0] recip_prod_hi;
  logic [31:0] quo_back;
  logic [31:0] rem_full;
  logic [52:0] recip_prod_lo;

  assign prod_vm  = 64'(req_r.value) * 64'(req_r.measure);
  assign prod_602 = 74'(moles_r) * 74'(roiwm_pkg::MOLECULES_PER_MOLE);
  assign mols_scaled = (|prod_602[73:64]) ? roiwm_pkg::SAT64 : prod_602[63:0];
  assign value_sh = {16'h0000, req_r.value, 16'h0000};
  assign accept   = start && !busy;
  assign req_idx  = request.roi_index;
  assign vol_now  = (mode == roiwm_pkg::MODE_VOL_CONC) || (mode == roiwm_pkg::MODE_VOL_COUNT);
  assign hit_now  = vol_now && region_map_enabled && (req_idx < nreg);

  // The value shifted by 16 divided by 602 splits into the value divided by 602,
  // shifted by 16, plus the remainder shifted by 16 divided by 602.
  assign recip_prod_hi = 65'(req_r.value) * 65'(RECIP_HI);
  assign quo_back      = 32'({9'd0, quo_hi} * 32'(roiwm_pkg::MOLECULES_PER_MOLE));
  assign rem_full      = req_r.value - quo_back;
  assign recip_prod_lo = 53'({rem_lo, 16'h0000}) * 53'(RECIP_LO);

  // Bin update for the accumulate step.
  roiwm_pkg::bin_t region_cur;
  roiwm_pkg::bin_t region_new;
  roiwm_pkg::bin_t total_new;

  always_comb begin
    region_cur = rd_valid ? rd_data : '0;
    region_new = region_cur;
    region_new.measure = roiwm_pkg::sat_add(region_cur.measure, 64'(req_r.measure));
    total_new = total;
    if (req_r.included) begin
      region_new.moles     = roiwm_pkg::sat_add(region_cur.moles, moles_r);
      region_new.molecules = roiwm_pkg::sat_add(region_cur.molecules, mols_r);
      total_new.moles      = roiwm_pkg::sat_add(total.moles, moles_r);
      total_new.molecules  = roiwm_pkg::sat_add(total.molecules, mols_r);
      total_new.measure    = roiwm_pkg::sat_add(total.measure, 64'(req_r.measure));
    end
  end

  // Bin of the column being flushed.
  roiwm_pkg::bin_t col_bin;
  logic [6:0] col_prev;
  logic       col_last;

  assign col_bin  = (col == '0) ? total : region_cur;
  assign col_prev = col - 7'd1;
  assign col_last = (col + 7'd1) == ncols;

  always_comb begin
    rd_en = 1'b0;
    rd_addr = req_idx[AW-1:0];
    if (accept && hit_now) begin
      rd_en = 1'b1;
    end else if (state == F_READ && col != '0) begin
      rd_en = 1'b1;
      rd_addr = col_prev[AW-1:0];
    end
    wr_en   = (state == S_ACC) && region_hit;
    wr_addr = region_addr;
    wr_data = region_new;
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      bad_label_seen <= 1'b0;
      total <= '0;
      clear_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      clear_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_r <= request;
            elem_mode <= mode;
            region_hit <= hit_now;
            region_addr <= req_idx[AW-1:0];
            if (vol_now && region_map_enabled && !hit_now) begin
              bad_label_seen <= 1'b1;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          unique case (elem_mode)
            roiwm_pkg::MODE_VOL_CONC: begin
              moles_r <= prod_vm;
              state <= S_SCALE;
            end
            roiwm_pkg::MODE_VOL_COUNT: begin
              // Moles are the particle count divided by 602, truncated.
              quo_hi <= recip_prod_hi[64:42];
              mols_r <= value_sh;
              state <= S_REM;
            end
            roiwm_pkg::MODE_MEM_CONC: begin
              moles_r <= prod_vm;
              mols_r <= prod_vm;
              state <= S_ACC;
            end
            roiwm_pkg::MODE_MEM_COUNT: begin
              moles_r <= value_sh;
              mols_r <= value_sh;
              state <= S_ACC;
            end
            default: ;
          endcase
        end
        S_REM: begin
          rem_lo <= rem_full[9:0];
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (elem_mode == roiwm_pkg::MODE_VOL_COUNT) begin
            moles_r <= {25'd0, quo_hi, recip_prod_lo[51:36]};
          end else begin
            mols_r <= mols_scaled;
          end
          state <= S_ACC;
        end
        S_ACC: begin
          total <= total_new;
          if (req_r.last_element) begin
            // The flush uses the mode of the last element and the grand total
            // as it stands after that element.
            col <= '0;
            ncols <= ((elem_mode == roiwm_pkg::MODE_VOL_CONC) ||
                      (elem_mode == roiwm_pkg::MODE_VOL_COUNT)) ? 7'(nreg) + 7'd1 : 7'd1;
            dz <= total_new.measure == '0;
            state <= F_READ;
          end else begin
            state <= S_IDLE;
          end
        end
        F_READ: begin
          state <= F_CALC;
        end
        F_CALC: begin
          if (col_bin.measure == '0) begin
            // An empty grand total averages to zero; an empty region keeps its
            // mole sum unscaled.
            result_valid <= 1'b1;
            result.column <= col[3:0];
            result.total_molecules <= col_bin.molecules;
            result.average <= (col == '0) ? '0 : col_bin.moles;
            result.divide_by_zero <= dz;
            result.index_error <= bad_label_seen;
            result.last_result <= col_last;
            if (col_last) begin
              total <= '0;
              bad_label_seen <= 1'b0;
              clear_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              col <= col + 7'd1;
              state <= F_READ;
            end
          end else begin
            div_quo <= {col_bin.moles, 16'h0000};
            div_rem <= '0;
            div_den <= col_bin.measure;
            div_cnt <= '0;
            state <= F_DIV;
          end
        end
        F_DIV: begin
          div_quo <= div_quo_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt + CW'(1);
          if (div_cnt == CW'(DIV_STEPS - 1)) begin
            result_valid <= 1'b1;
            result.column <= col[3:0];
            result.total_molecules <= col_bin.molecules;
            result.average <= (|div_quo_next[79:64]) ? roiwm_pkg::SAT64 : div_quo_next[63:0];
            result.divide_by_zero <= dz;
            result.index_error <= bad_label_seen;
            result.last_result <= col_last;
            if (col_last) begin
              total <= '0;
              bad_label_seen <= 1'b0;
              clear_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              col <= col + 7'd1;
              state <= F_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The final column of a time point hands control straight back to the idle state.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_result |-> !busy)
    else $error("block still busy after the final column");

  // Columns are separated by the F_READ state, so no two arrive in adjacent cycles.
  a_no_adjacent: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("two columns in adjacent cycles");

  // An accepted request always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not start work");

  // The region memory is never read and written in the same cycle.
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("region memory read and write collide");

endmodule
